### rtl/core/sesc_pkg.sv
// ----------------------------------------------------------------------------
// sesc_pkg
// Shared types and constants for the synth event stream checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sesc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CFG_LAST_FRAME     = 2'd0;
    localparam logic [1:0] CFG_FIRST_SEQUENCE = 2'd1;
    localparam logic [1:0] CFG_FRAME_LIMIT    = 2'd2;

    localparam logic [1:0] KIND_REG_WRITE = 2'd0;
    localparam logic [1:0] KIND_KEY       = 2'd1;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_FRAME    = 4'd1;
    localparam logic [3:0] ST_TIME     = 4'd2;
    localparam logic [3:0] ST_OVERFLOW = 4'd3;
    localparam logic [3:0] ST_SEQUENCE = 4'd4;
    localparam logic [3:0] ST_TYPE     = 4'd5;
    localparam logic [3:0] ST_PAYLOAD  = 4'd6;
    localparam logic [3:0] ST_REGISTER = 4'd7;
    localparam logic [3:0] ST_KEY      = 4'd8;

    typedef struct packed {
        logic        batch_start;
        logic        batch_end;
        logic [63:0] sample_time;
        logic [63:0] seq_number;
        logic [1:0]  event_kind;
        logic [7:0]  channel_base;
        logic [15:0] reg_number;
        logic [7:0]  key_channel;
        logic [7:0]  key_reserved;
    } event_t;

    typedef struct packed {
        logic [3:0] item_status;
        logic [3:0] batch_status;
        logic       batch_done;
    } result_t;

    // classified event between front and back
    typedef struct packed {
        logic        batch_start;
        logic        batch_end;
        logic        frame_err;
        logic        time_over;
        logic [3:0]  pay_status;
        logic [63:0] sample_time;
        logic [63:0] seq_number;
    } class_t;

endpackage

`default_nettype wire

### rtl/core/sesc_fifo.sv
// ----------------------------------------------------------------------------
// sesc_fifo
// Small register FIFO; push and pop may transfer in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sesc_fifo #(
    parameter int Width = 8,
    parameter int Depth = sesc_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [Width-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [Width-1:0]      rdata,
    output logic                  empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

    logic [Width-1:0] mem [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DepthCnt);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sesc_front.sv
// ----------------------------------------------------------------------------
// sesc_front
// Stateless classification: frame range, timestamp bound, payload decode.
// ----------------------------------------------------------------------------
`default_nettype none

module sesc_front (
    input  wire sesc_pkg::event_t ev,
    input  wire logic [63:0]      last_frame,
    input  wire logic [63:0]      frame_limit,
    output sesc_pkg::class_t      cls
);

    function automatic logic reg_ok(input logic [7:0] base, input logic [15:0] regn);
        logic [15:0] grp;
        logic        ok;
        grp = (regn < 16'h00a0) ? (regn & 16'h00f0) : (regn & 16'h00fc);
        case (grp)
            16'h0030, 16'h0040, 16'h0050, 16'h0060, 16'h0070, 16'h0080,
            16'h00a0, 16'h00a4, 16'h00a8, 16'h00ac, 16'h00b0, 16'h00b4:
                ok = 1'b1;
            // high register numbers can alias into this group
            16'h0090:
                ok = (regn < 16'h00a0);
            default:
                ok = 1'b0;
        endcase
        if (base > 8'd3 || regn[1:0] == 2'b11)
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    logic [3:0] pay;

    always_comb
    begin
        case (ev.event_kind)
            sesc_pkg::KIND_REG_WRITE:
                pay = reg_ok(ev.channel_base, ev.reg_number) ?
                      sesc_pkg::ST_OK : sesc_pkg::ST_REGISTER;
            sesc_pkg::KIND_KEY:
            begin
                if (ev.key_channel > 8'd5)
                    pay = sesc_pkg::ST_KEY;
                else if (ev.key_reserved != 8'd0)
                    pay = sesc_pkg::ST_PAYLOAD;
                else
                    pay = sesc_pkg::ST_OK;
            end
            default:
                pay = sesc_pkg::ST_TYPE;
        endcase
    end

    assign cls.batch_start = ev.batch_start;
    assign cls.batch_end   = ev.batch_end;
    assign cls.frame_err   = (last_frame > frame_limit);
    assign cls.time_over   = (ev.sample_time > last_frame);
    assign cls.pay_status  = pay;
    assign cls.sample_time = ev.sample_time;
    assign cls.seq_number  = ev.seq_number;

endmodule

`default_nettype wire

### rtl/core/sesc_back.sv
// ----------------------------------------------------------------------------
// sesc_back
// Batch state: timestamp order, sequence check, sticky first error.
// ----------------------------------------------------------------------------
`default_nettype none

module sesc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [63:0]      first_sequence,
    input  wire sesc_pkg::class_t cls,
    input  wire logic             cls_empty,
    output logic                  cls_pop,
    output sesc_pkg::result_t     res,
    output logic                  res_push,
    input  wire logic             res_full
);

    logic [63:0] prior_time_reg, prior_time_next;
    logic [63:0] item_index_reg, item_index_next;
    logic [3:0]  first_error_reg, first_error_next;

    logic [63:0] idx, prior;
    logic [3:0]  ferr, st;
    logic [64:0] expect_seq;
    logic        go;

    assign go       = !cls_empty && !res_full;
    assign cls_pop  = go;
    assign res_push = go;

    assign idx        = cls.batch_start ? '0 : item_index_reg;
    assign prior      = cls.batch_start ? '0 : prior_time_reg;
    assign ferr       = cls.batch_start ? sesc_pkg::ST_OK : first_error_reg;
    assign expect_seq = {1'b0, first_sequence} + {1'b0, idx};

    always_comb
    begin
        if (cls.frame_err)
            st = sesc_pkg::ST_FRAME;
        else if ((idx != '0 && cls.sample_time < prior) || cls.time_over)
            st = sesc_pkg::ST_TIME;
        else if (expect_seq[64])
            st = sesc_pkg::ST_OVERFLOW;
        else if (cls.seq_number != expect_seq[63:0])
            st = sesc_pkg::ST_SEQUENCE;
        else
            st = cls.pay_status;

        prior_time_next  = (st == sesc_pkg::ST_OK) ? cls.sample_time : prior;
        first_error_next = (ferr == sesc_pkg::ST_OK) ? st : ferr;
        item_index_next  = (&idx) ? idx : idx + 64'd1;
    end

    assign res.item_status  = st;
    assign res.batch_status = first_error_next;
    assign res.batch_done   = cls.batch_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_time_reg  <= '0;
            item_index_reg  <= '0;
            first_error_reg <= sesc_pkg::ST_OK;
        end
        else if (go)
        begin
            prior_time_reg  <= prior_time_next;
            item_index_reg  <= item_index_next;
            first_error_reg <= first_error_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/synth_event_stream_checker_unit.sv
// ----------------------------------------------------------------------------
// synth_event_stream_checker_unit
// Checks timestamped sound-chip events; one result per event.
// ----------------------------------------------------------------------------
// Channel   Handshake        Payload
// input     push / full      item   (sesc_pkg::event_t)
// result    pop / empty      result (sesc_pkg::result_t)
// config    cfg_we           cfg_index, cfg_wdata
//
// One event per cycle sustained unless full stalls the input. An event is
// registered in the classify queue, its result in the result queue. The batch
// state update (64-bit compare and add) in the back stage sets the cycle.
// Reset clears batch state and config (capacity to all ones), no sweep.
// A stalled result side fills the result queue, then the classify queue,
// then raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module synth_event_stream_checker_unit #(
    parameter int QueueDepth = sesc_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire sesc_pkg::event_t  item,
    output logic                   empty,
    input  wire logic              pop,
    output sesc_pkg::result_t      result,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_wdata
);

    localparam int ClsW = $bits(sesc_pkg::class_t);
    localparam int ResW = $bits(sesc_pkg::result_t);

    logic [63:0] last_frame_reg;
    logic [63:0] first_sequence_reg;
    logic [63:0] frame_limit_reg;

    sesc_pkg::class_t  cls_in, cls_out;
    sesc_pkg::result_t res_in;
    logic              cls_empty, cls_pop;
    logic              res_push, res_full;
    logic [ClsW-1:0]   cls_rdata;
    logic [ResW-1:0]   res_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_frame_reg     <= '0;
            first_sequence_reg <= '0;
            frame_limit_reg    <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sesc_pkg::CFG_LAST_FRAME:     last_frame_reg     <= cfg_wdata;
                sesc_pkg::CFG_FIRST_SEQUENCE: first_sequence_reg <= cfg_wdata;
                sesc_pkg::CFG_FRAME_LIMIT:    frame_limit_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    sesc_front u_front (
        .ev          (item),
        .last_frame  (last_frame_reg),
        .frame_limit (frame_limit_reg),
        .cls         (cls_in)
    );

    sesc_fifo #(
        .Width (ClsW),
        .Depth (QueueDepth)
    ) u_cls_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls_in),
        .full  (full),
        .pop   (cls_pop),
        .rdata (cls_rdata),
        .empty (cls_empty)
    );

    assign cls_out = sesc_pkg::class_t'(cls_rdata);

    sesc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .first_sequence (first_sequence_reg),
        .cls            (cls_out),
        .cls_empty      (cls_empty),
        .cls_pop        (cls_pop),
        .res            (res_in),
        .res_push       (res_push),
        .res_full       (res_full)
    );

    sesc_fifo #(
        .Width (ResW),
        .Depth (QueueDepth)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign result = sesc_pkg::result_t'(res_rdata);

endmodule

`default_nettype wire

### dv/synth_event_stream_checker_unit_test.sv
// ----------------------------------------------------------------------------
// synth_event_stream_checker_unit_test
// Self-checking bench for the event stream checker. A driver pushes queued
// events, a receiver pops results and a monitor compares each transfer with
// a local prediction of item and batch status. Runs directed corner events,
// then randomized batches under several register settings and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module synth_event_stream_checker_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES          = '1;
    localparam logic [1:0]  CFG_UNUSED        = 2'd3;
    localparam logic [1:0]  REG_WRITE         = sesc_pkg::KIND_REG_WRITE;
    localparam logic [1:0]  KEY_EVENT         = sesc_pkg::KIND_KEY;
    localparam logic [7:0]  KEY_CHANNEL_MAX   = 8'd5;
    localparam logic [7:0]  REG_BASE_MAX      = 8'd3;
    localparam int          RECV_HOLD_CYCLES  = 120;
    localparam int          DRAIN_GAP         = 4;
    localparam int          WATCHDOG_LIMIT    = 4000;
    localparam int          SEGMENT_ITEMS     = 265;
    localparam int          SEGMENTS          = 6;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    logic              full;
    sesc_pkg::event_t  item      = '0;
    logic              empty;
    logic              pop       = 1'b0;
    sesc_pkg::result_t result;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [63:0]       cfg_wdata = '0;

    // register shadows
    logic [63:0] shadow_last_frame     = '0;
    logic [63:0] shadow_first_sequence = '0;
    logic [63:0] shadow_frame_limit    = '1;

    // batch tracking
    logic [63:0] trk_prior_time  = '0;
    logic [63:0] trk_item_index  = '0;
    logic [3:0]  trk_first_error = sesc_pkg::ST_OK;

    sesc_pkg::event_t  event_backlog[$];
    sesc_pkg::result_t expected_verdicts[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_request = 1'b0;
    int hold_left = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    logic [63:0] gen_time  = '0;
    logic [63:0] gen_index = '0;

    synth_event_stream_checker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_upto(input logic [63:0] lim);
        if (lim == ALL_ONES)
            return rand64();
        return rand64() % (lim + 64'd1);
    endfunction

    function automatic sesc_pkg::result_t predict_status(input sesc_pkg::event_t ev);
        sesc_pkg::result_t res;
        logic [3:0]  st;
        logic [15:0] grp;
        logic        reg_ok;
        if (ev.batch_start)
        begin
            trk_prior_time  = '0;
            trk_item_index  = '0;
            trk_first_error = sesc_pkg::ST_OK;
        end
        grp = (ev.reg_number < 16'h00a0) ? (ev.reg_number & 16'h00f0)
                                         : (ev.reg_number & 16'h00fc);
        case (grp)
            16'h0030, 16'h0040, 16'h0050, 16'h0060, 16'h0070, 16'h0080:
                reg_ok = 1'b1;
            16'h0090:
                reg_ok = ev.reg_number < 16'h00a0;
            16'h00a0, 16'h00a4, 16'h00a8, 16'h00ac, 16'h00b0, 16'h00b4:
                reg_ok = 1'b1;
            default:
                reg_ok = 1'b0;
        endcase
        if (ev.channel_base > REG_BASE_MAX || ev.reg_number[1:0] == 2'b11)
            reg_ok = 1'b0;

        if (shadow_last_frame > shadow_frame_limit)
            st = sesc_pkg::ST_FRAME;
        else if (trk_item_index != 0 && ev.sample_time < trk_prior_time)
            st = sesc_pkg::ST_TIME;
        else if (ev.sample_time > shadow_last_frame)
            st = sesc_pkg::ST_TIME;
        else if (trk_item_index > ~shadow_first_sequence)
            st = sesc_pkg::ST_OVERFLOW;
        else if (ev.seq_number != shadow_first_sequence + trk_item_index)
            st = sesc_pkg::ST_SEQUENCE;
        else if (ev.event_kind == REG_WRITE)
            st = reg_ok ? sesc_pkg::ST_OK : sesc_pkg::ST_REGISTER;
        else if (ev.event_kind == KEY_EVENT)
        begin
            if (ev.key_channel > KEY_CHANNEL_MAX)
                st = sesc_pkg::ST_KEY;
            else
                st = (ev.key_reserved == 8'd0) ? sesc_pkg::ST_OK : sesc_pkg::ST_PAYLOAD;
        end
        else
            st = sesc_pkg::ST_TYPE;

        if (st == sesc_pkg::ST_OK)
            trk_prior_time = ev.sample_time;
        if (trk_first_error == sesc_pkg::ST_OK)
            trk_first_error = st;
        if (trk_item_index != ALL_ONES)
            trk_item_index++;

        res.item_status  = st;
        res.batch_status = trk_first_error;
        res.batch_done   = ev.batch_end;
        return res;
    endfunction

    function automatic sesc_pkg::event_t mk_event(input logic start, input logic tail,
                                        input logic [63:0] t, input logic [63:0] seq,
                                        input logic [1:0] kind, input logic [7:0] base,
                                        input logic [15:0] regnum, input logic [7:0] kch,
                                        input logic [7:0] kres);
        sesc_pkg::event_t ev;
        ev.batch_start  = start;
        ev.batch_end    = tail;
        ev.sample_time  = t;
        ev.seq_number   = seq;
        ev.event_kind   = kind;
        ev.channel_base = base;
        ev.reg_number   = regnum;
        ev.key_channel  = kch;
        ev.key_reserved = kres;
        return ev;
    endfunction

    task automatic write_config(input logic [63:0] ef, input logic [63:0] fs,
                                input logic [63:0] cap);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sesc_pkg::CFG_LAST_FRAME;
        cfg_wdata <= ef;
        @(negedge clk);
        cfg_index <= sesc_pkg::CFG_FIRST_SEQUENCE;
        cfg_wdata <= fs;
        @(negedge clk);
        cfg_index <= sesc_pkg::CFG_FRAME_LIMIT;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= rand64();
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_last_frame     = ef;
        shadow_first_sequence = fs;
        shadow_frame_limit    = cap;
    endtask

    task automatic wait_drained();
        while (event_backlog.size() != 0 || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic add_random_items(input int count);
        int     left;
        int     len;
        int     n;
        int     r;
        int     g;
        logic   start;
        logic [7:0]  lo;
        logic [63:0] room;
        sesc_pkg::event_t ev;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(1, 24);
            if (len > left)
                len = left;
            start = ($urandom_range(0, 9) != 0);
            if (start)
            begin
                gen_index = '0;
                gen_time  = rand_upto(shadow_last_frame >> $urandom_range(0, 63));
            end
            if (gen_time > shadow_last_frame)
                gen_time = shadow_last_frame;
            for (n = 0; n < len; n++)
            begin
                ev.channel_base = 8'($urandom);
                ev.reg_number   = 16'($urandom);
                ev.key_channel  = 8'($urandom);
                ev.key_reserved = 8'($urandom);
                if ($urandom_range(0, 19) == 0)
                begin
                    // noise
                    ev.batch_start = 1'($urandom);
                    ev.batch_end   = 1'($urandom);
                    ev.sample_time = rand64();
                    ev.seq_number  = rand64();
                    ev.event_kind  = 2'($urandom);
                end
                else
                begin
                    ev.batch_start = start && (n == 0);
                    ev.batch_end   = (n == len - 1);
                    if (n != 0 || !start)
                    begin
                        room = shadow_last_frame - gen_time;
                        if ($urandom_range(0, 15) == 0)
                            gen_time = shadow_last_frame;
                        else
                            gen_time += rand_upto(room >> $urandom_range(1, 63));
                    end
                    ev.sample_time = gen_time;
                    ev.seq_number  = shadow_first_sequence + gen_index;
                    r = $urandom_range(0, 99);
                    if (r < 47)
                        ev.event_kind = REG_WRITE;
                    else if (r < 94)
                        ev.event_kind = KEY_EVENT;
                    else
                        ev.event_kind = 2'($urandom_range(2, 3));
                    if (ev.event_kind == REG_WRITE && $urandom_range(0, 3) != 0)
                    begin
                        g = $urandom_range(0, 12);
                        if (g < 7)
                            lo = 8'((g + 3) * 16 + $urandom_range(0, 3) * 4
                                    + $urandom_range(0, 2));
                        else
                            lo = 8'(8'ha0 + (g - 7) * 4 + $urandom_range(0, 2));
                        ev.channel_base = 8'($urandom_range(0, 3));
                        ev.reg_number   = {($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                                       : 8'h00, lo};
                    end
                    if (ev.event_kind == KEY_EVENT && $urandom_range(0, 3) != 0)
                    begin
                        ev.key_channel  = 8'($urandom_range(0, 5));
                        ev.key_reserved = 8'd0;
                    end
                    case ($urandom_range(0, 29))
                        0: ev.seq_number ^= 64'd1 << $urandom_range(0, 63);
                        1: ev.seq_number = rand64();
                        2:
                        begin
                            if (gen_time != 0)
                                ev.sample_time = rand_upto(gen_time - 64'd1);
                        end
                        3:
                        begin
                            if (shadow_last_frame != ALL_ONES)
                                ev.sample_time = shadow_last_frame + 64'd1
                                    + rand_upto(ALL_ONES - shadow_last_frame - 64'd1);
                        end
                        default: ;
                    endcase
                end
                gen_index++;
                event_backlog.push_back(ev);
            end
            left -= len;
        end
    endtask

    // event driver
    always @(negedge clk)
    begin
        if (rst_n && event_backlog.size() != 0
            && $urandom_range(0, 99) >= send_idle_pct)
        begin
            push <= 1'b1;
            item <= event_backlog[0];
        end
        else
            push <= 1'b0;
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = RECV_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        sesc_pkg::result_t want;
        logic              moved;
        moved = cfg_we;
        if (rst_n && pop && !empty)
        begin
            moved = 1'b1;
            if (expected_verdicts.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (result.item_status !== want.item_status)
                begin
                    $error("item_status: expected %0d, got %0d",
                           want.item_status, result.item_status);
                    fail_count++;
                end
                if (result.batch_status !== want.batch_status)
                begin
                    $error("batch_status: expected %0d, got %0d",
                           want.batch_status, result.batch_status);
                    fail_count++;
                end
                if (result.batch_done !== want.batch_done)
                begin
                    $error("batch_done: expected %0d, got %0d",
                           want.batch_done, result.batch_done);
                    fail_count++;
                end
            end
        end
        if (rst_n && push && !full)
        begin
            moved = 1'b1;
            expected_verdicts.push_back(predict_status(item));
            void'(event_backlog.pop_front());
        end
        if (!rst_n || moved)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int seg;
        logic [63:0] ef;
        logic [63:0] fs;
        logic [63:0] cap;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 67;
        write_config(64'd1000, 64'd10, ALL_ONES);
        event_backlog.push_back(mk_event(1, 0, 0, 10, REG_WRITE, 0, 16'h0030, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 5, 11, KEY_EVENT, 8'hff, 16'hffff, 5, 0));
        event_backlog.push_back(mk_event(0, 0, 3, 12, REG_WRITE, 1, 16'h0044, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1001, 13, REG_WRITE, 1, 16'h0044, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 99, REG_WRITE, 1, 16'h0044, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 15, 2'd2, 0, 16'h0030, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 16, 2'd3, 0, 16'h0030, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 17, KEY_EVENT, 0, 0, 6, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 18, KEY_EVENT, 0, 0, 0, 8'hff));
        event_backlog.push_back(mk_event(0, 0, 1000, 19, REG_WRITE, 4, 16'h0030, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 20, REG_WRITE, 3, 16'h0033, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 21, REG_WRITE, 3, 16'h009e, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 22, REG_WRITE, 0, 16'h01a4, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 23, REG_WRITE, 0, 16'h0190, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 24, REG_WRITE, 2, 16'h00b8, 0, 0));
        event_backlog.push_back(mk_event(0, 0, 1000, 25, REG_WRITE, 0, 16'hffff, 0, 0));
        event_backlog.push_back(mk_event(0, 1, 1000, 26, REG_WRITE, 0, 16'h0020, 0, 0));
        // no batch_start after batch_end: batch keeps running
        event_backlog.push_back(mk_event(0, 1, 1000, 27, KEY_EVENT, 0, 0, 0, 0));
        wait_drained();

        // sequence overflow near the top of the range
        write_config(ALL_ONES, ALL_ONES - 64'd2, ALL_ONES);
        event_backlog.push_back(mk_event(1, 0, ALL_ONES, ALL_ONES - 64'd2, KEY_EVENT,
                                         0, 0, 0, 0));
        event_backlog.push_back(mk_event(0, 0, ALL_ONES, ALL_ONES - 64'd1, KEY_EVENT,
                                         0, 0, 1, 0));
        event_backlog.push_back(mk_event(0, 0, ALL_ONES, ALL_ONES, KEY_EVENT, 0, 0, 2, 0));
        event_backlog.push_back(mk_event(0, 1, ALL_ONES, 64'd0, KEY_EVENT, 0, 0, 3, 0));
        wait_drained();

        // last frame beyond the limit
        write_config(64'd6, 64'd0, 64'd5);
        event_backlog.push_back(mk_event(1, 1, 0, 0, REG_WRITE, 0, 16'h0030, 0, 0));
        wait_drained();

        write_config(64'd0, 64'd0, 64'd0);
        event_backlog.push_back(mk_event(1, 1, 0, 0, KEY_EVENT, 0, 0, 5, 0));
        wait_drained();

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:
                begin
                    ef = ALL_ONES;
                    fs = rand64();
                    cap = ALL_ONES;
                end
                1:
                begin
                    ef = rand64();
                    fs = ALL_ONES - 64'($urandom_range(0, 40));
                    cap = ALL_ONES;
                end
                2:
                begin
                    ef = 64'($urandom_range(0, 5000));
                    fs = '0;
                    cap = ef;
                end
                3:
                begin
                    ef = rand64();
                    fs = rand64();
                    cap = rand64();
                end
                4:
                begin
                    ef = '0;
                    fs = rand64();
                    cap = '0;
                end
                default:
                begin
                    ef = rand64();
                    fs = rand64();
                    cap = ALL_ONES;
                end
            endcase
            if (seg < 2)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 67;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_config(ef, fs, cap);
            // back up the result side while events keep coming
            if (seg == 4)
                hold_request = 1'b1;
            add_random_items(SEGMENT_ITEMS);
            // sender pauses until everything has come back
            wait_drained();
        end

        if (expected_verdicts.size() != 0)
        begin
            $error("%0d results never arrived", expected_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
